>>> hw/rtl/tsp_pkg.sv
// Shared types and constants for the greedy tour solver with tree lookahead.
package tsp_pkg;
  localparam int MAX_VERTICES = 16;
  localparam int WEIGHT_BITS  = 16;
  localparam int unsigned VERTEX_BITS = 4;
  localparam int unsigned COST_BITS   = 32;
  localparam int unsigned TOUR_BITS   = 21;
  localparam logic [COST_BITS-1:0] INF_MARK = 32'h3FFF_FFFF;

  typedef struct packed {
    logic [3:0]  row_index;
    logic [3:0]  col_index;
    logic [15:0] edge_weight;
    logic        last_entry;
  } tsp_in_t;

  typedef struct packed {
    logic [3:0]  path_vertex;
    logic [20:0] tour_cost;
    logic        no_path;
    logic        last_result;
  } tsp_out_t;

  function automatic logic [COST_BITS-1:0] sat_add(input logic [COST_BITS-1:0] a,
                                                   input logic [COST_BITS-1:0] b);
    logic [COST_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = (s > {1'b0, INF_MARK}) ? INF_MARK : s[COST_BITS-1:0];
  endfunction
endpackage

>>> hw/rtl/tsp_if.sv
// Valid/ready channel carrying one payload item.
interface tsp_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/tsp_tour_mst_lookahead_core.sv
// Top level: matrix load, greedy tour search with tree lookahead, result stream.
// Usage:
//   in  : one matrix entry per item (row, column, weight; zero weight = no edge).
//         Entries are taken one per cycle while loading. The item with last_entry
//         set writes its entry and starts a solve over the first vertex_count vertices.
//   out : vertex 0, the tour vertices, then vertex 0 again, each with the total
//         cost; last_result marks the final item. When no tour exists a single
//         item with no_path set is sent.
//   cfg : cfg_we writes vertex_count (reset 16); write only while idle.
// Solve: the matrix is read through one registered read port, one entry at a
//   time, with a Prim pass for each candidate vertex. in_ready is low during
//   the solve and while results drain.
// Reset: synchronous, active low; clears control and sets vertex_count to 16.
//   The matrix holds no reset value and must be written before use.
// A stalled receiver holds the current result item; nothing is dropped.
module tsp_tour_mst_lookahead_core (
  input  logic clk,
  input  logic rst_n,
  tsp_if.sink   in_ch,
  tsp_if.source out_ch,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata
);
  import tsp_pkg::*;

  localparam int VB = $clog2(MAX_VERTICES);
  localparam int NB = VB + 1;

  typedef enum logic [3:0] {
    S_LOAD, S_STEP, S_CAND, S_PINIT, S_PSEL, S_PADD, S_PUPD,
    S_CHOOSE, S_CLOSE, S_EMIT, S_NOPATH
  } st_t;

  st_t st_r;
  logic [4:0] vcount_r;
  logic [WEIGHT_BITS-1:0] mem [MAX_VERTICES*MAX_VERTICES];
  logic [WEIGHT_BITS-1:0] rd_r;
  logic [2*VB-1:0] raddr;

  logic [NB-1:0] n_r, step_r, v_r, i_r, k_r, total_r, out_k_r;
  logic [VB-1:0] cur_r, u_r, best_v_r;
  logic best_have_r, have_r;
  logic [MAX_VERTICES-1:0] vis_r, excl_r, tree_r;
  logic [COST_BITS-1:0] mec_r [MAX_VERTICES];
  logic [COST_BITS-1:0] sum_r, best_s_r, ew_r, run_r;
  logic [COST_BITS-1:0] best_ew_r;
  logic [VB-1:0] path_r [MAX_VERTICES+1];
  logic rd_pend_r;

  logic [NB-1:0] n_eff;
  assign n_eff = (vcount_r == 5'd0) ? NB'(1) :
                 (32'(vcount_r) > MAX_VERTICES) ? NB'(MAX_VERTICES) : NB'(vcount_r);

  logic wr_ok;
  assign wr_ok = (32'(in_ch.data.row_index) < MAX_VERTICES) &&
                 (32'(in_ch.data.col_index) < MAX_VERTICES);
  logic acc;
  assign acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st_r == S_LOAD);

  logic [VB-1:0] ra_row, ra_col;
  always_comb begin
    ra_row = cur_r;
    ra_col = v_r[VB-1:0];
    case (st_r)
      S_PUPD:  begin ra_row = u_r; ra_col = i_r[VB-1:0]; end
      S_CLOSE: begin ra_row = cur_r; ra_col = '0; end
      default: ;
    endcase
    raddr = {ra_row, ra_col};
  end

  always_ff @(posedge clk) begin
    if (acc && wr_ok)
      mem[{in_ch.data.row_index[VB-1:0], in_ch.data.col_index[VB-1:0]}]
        <= in_ch.data.edge_weight[WEIGHT_BITS-1:0];
    rd_r <= mem[raddr];
  end

  logic [COST_BITS-1:0] rdw;
  assign rdw = COST_BITS'(rd_r);
  logic [COST_BITS-1:0] cand_score;
  assign cand_score = sat_add(ew_r, sum_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD;
      vcount_r <= 5'd16;
      rd_pend_r <= 1'b0;
    end else begin
      if (cfg_we) vcount_r <= cfg_wdata;
      rd_pend_r <= 1'b0;
      case (st_r)
        S_LOAD: if (acc && in_ch.data.last_entry) begin
          n_r <= n_eff; cur_r <= '0; vis_r <= MAX_VERTICES'(1);
          run_r <= '0; path_r[0] <= '0; step_r <= NB'(1);
          st_r <= S_STEP;
        end
        S_STEP: begin
          if (step_r >= n_r) begin
            rd_pend_r <= 1'b1; st_r <= S_CLOSE;
          end else begin
            best_s_r <= INF_MARK; best_have_r <= 1'b0;
            v_r <= '0; rd_pend_r <= 1'b1; st_r <= S_CAND;
          end
        end
        S_CAND: if (!rd_pend_r) begin
          if (v_r >= n_r) st_r <= S_CHOOSE;
          else if (vis_r[v_r[VB-1:0]] || rdw == '0) begin
            v_r <= v_r + NB'(1); rd_pend_r <= 1'b1;
          end else begin
            ew_r <= rdw;
            excl_r <= vis_r | (MAX_VERTICES'(1) << v_r[VB-1:0]);
            i_r <= '0; total_r <= '0; have_r <= 1'b0;
            st_r <= S_PINIT;
          end
        end
        S_PINIT: begin
          if (i_r < n_r) begin
            mec_r[i_r[VB-1:0]] <= INF_MARK;
            if (!excl_r[i_r[VB-1:0]]) begin
              total_r <= total_r + NB'(1);
              if (!have_r) begin have_r <= 1'b1; u_r <= i_r[VB-1:0]; end
            end
            i_r <= i_r + NB'(1);
          end else begin
            sum_r <= '0; tree_r <= '0; k_r <= '0;
            if (total_r <= NB'(1)) st_r <= S_PADD;
            else begin
              mec_r[u_r] <= '0; i_r <= '0; have_r <= 1'b0; st_r <= S_PSEL;
            end
          end
        end
        S_PSEL: begin
          if (i_r < n_r) begin
            if (!excl_r[i_r[VB-1:0]] && !tree_r[i_r[VB-1:0]] &&
                (!have_r || mec_r[i_r[VB-1:0]] < mec_r[u_r])) begin
              u_r <= i_r[VB-1:0]; have_r <= 1'b1;
            end
            i_r <= i_r + NB'(1);
          end else if (!have_r) begin
            k_r <= total_r; st_r <= S_PADD;
          end else begin
            tree_r[u_r] <= 1'b1;
            sum_r <= sat_add(sum_r, mec_r[u_r]);
            i_r <= '0; rd_pend_r <= 1'b1; st_r <= S_PUPD;
          end
        end
        S_PUPD: if (!rd_pend_r) begin
          if (i_r >= n_r) begin
            k_r <= k_r + NB'(1);
            if (k_r + NB'(1) >= total_r) st_r <= S_PADD;
            else begin i_r <= '0; have_r <= 1'b0; st_r <= S_PSEL; end
          end else begin
            if (!excl_r[i_r[VB-1:0]] && !tree_r[i_r[VB-1:0]] &&
                rdw != '0 && rdw < mec_r[i_r[VB-1:0]])
              mec_r[i_r[VB-1:0]] <= rdw;
            i_r <= i_r + NB'(1); rd_pend_r <= 1'b1;
          end
        end
        S_PADD: begin
          if (total_r <= NB'(1)) sum_r <= '0;
          else if (cand_score < best_s_r) begin
            best_s_r <= cand_score; best_v_r <= v_r[VB-1:0]; best_have_r <= 1'b1;
          end
          if (total_r <= NB'(1) && ew_r < best_s_r) begin
            best_s_r <= ew_r; best_v_r <= v_r[VB-1:0]; best_have_r <= 1'b1;
          end
          v_r <= v_r + NB'(1); rd_pend_r <= 1'b1; st_r <= S_CAND;
        end
        S_CHOOSE: begin
          if (!best_have_r) st_r <= S_NOPATH;
          else begin
            cur_r <= best_v_r;
            path_r[step_r] <= best_v_r;
            vis_r[best_v_r] <= 1'b1;
            step_r <= step_r + NB'(1);
            run_r <= run_r + best_ew_r;
            st_r <= S_STEP;
          end
        end
        S_CLOSE: if (!rd_pend_r) begin
          if (rdw == '0) st_r <= S_NOPATH;
          else begin
            run_r <= run_r + rdw; path_r[n_r] <= '0;
            out_k_r <= '0; st_r <= S_EMIT;
          end
        end
        S_EMIT: if (out_ch.ready && out_k_r == n_r) st_r <= S_LOAD;
          else if (out_ch.ready) out_k_r <= out_k_r + NB'(1);
        S_NOPATH: if (out_ch.ready) st_r <= S_LOAD;
        default: st_r <= S_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_PADD && ((total_r > NB'(1) && cand_score < best_s_r) ||
        (total_r <= NB'(1) && ew_r < best_s_r)))
      best_ew_r <= ew_r;
  end

  always_comb begin
    out_ch.valid = (st_r == S_EMIT) || (st_r == S_NOPATH);
    out_ch.data.path_vertex = (st_r == S_EMIT) ? 4'(path_r[out_k_r]) : 4'd0;
    out_ch.data.tour_cost   = (st_r == S_EMIT) ? run_r[TOUR_BITS-1:0] : '0;
    out_ch.data.no_path     = (st_r == S_NOPATH);
    out_ch.data.last_result = (st_r == S_NOPATH) || (out_k_r == n_r);
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid) else $error("ready while emitting");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
  a_nopath: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.no_path |-> out_ch.data.last_result)
    else $error("no_path not last");
endmodule

>>> sim/tsp_tour_checker.sv
`timescale 1ns / 1ps
// Checker: predicts tour results from observed matrix items and compares the output stream.
module tsp_tour_checker
  import tsp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  tsp_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  tsp_out_t out_data,
  input  logic     cfg_we,
  input  logic [4:0] cfg_wdata,
  output int       pending_count,
  output int       error_count
);
  logic [15:0] weight_mat [16][16];
  logic [4:0]  vertex_cnt;
  tsp_out_t    tour_q [$];

  assign pending_count = tour_q.size();

  task automatic queue_result(input tsp_out_t r);
    tour_q = {tour_q, r};
  endtask

  function automatic logic [31:0] mst_cost(logic [15:0] excl, int n);
    logic [15:0] in_tree;
    logic [31:0] key [16];
    logic [31:0] sum;
    int total, start, u;
    bit found, have;
    total = 0;
    start = 0;
    found = 0;
    sum = 0;
    in_tree = '0;
    for (int i = 0; i < n; i++) begin
      if (!excl[i]) begin
        total++;
        if (!found) begin
          start = i;
          found = 1;
        end
      end
    end
    if (total <= 1) return 0;
    for (int i = 0; i < 16; i++) key[i] = INF_MARK;
    key[start] = 0;
    for (int k = 0; k < total; k++) begin
      u = 0;
      have = 0;
      for (int i = 0; i < n; i++) begin
        if (excl[i] || in_tree[i]) continue;
        if (!have || key[i] < key[u]) begin
          u = i;
          have = 1;
        end
      end
      if (!have) break;
      in_tree[u] = 1'b1;
      sum = sat_add(sum, key[u]);
      for (int i = 0; i < n; i++) begin
        if (excl[i] || in_tree[i]) continue;
        if (weight_mat[u][i] != 0 && {16'd0, weight_mat[u][i]} < key[i])
          key[i] = {16'd0, weight_mat[u][i]};
      end
    end
    return sum;
  endfunction

  task automatic solve_tour();
    int n, cur, best_v;
    logic [15:0] visited;
    logic [31:0] cost, best, score;
    logic [3:0] path [17];
    tsp_out_t r;
    n = (vertex_cnt < 1) ? 1 : ((vertex_cnt > 16) ? 16 : vertex_cnt);
    cur = 0;
    visited = 16'h0001;
    cost = 0;
    path[0] = 0;
    for (int step = 1; step < n; step++) begin
      best = INF_MARK;
      best_v = 16;
      for (int v = 0; v < n; v++) begin
        if (visited[v] || weight_mat[cur][v] == 0) continue;
        score = {16'd0, weight_mat[cur][v]} + mst_cost(visited | (16'h1 << v), n);
        if (score > INF_MARK) score = INF_MARK;
        if (score < best) begin
          best = score;
          best_v = v;
        end
      end
      if (best_v >= 16) begin
        r = '{path_vertex: 0, tour_cost: 0, no_path: 1'b1, last_result: 1'b1};
        queue_result(r);
        return;
      end
      cost += weight_mat[cur][best_v];
      cur = best_v;
      path[step] = cur[3:0];
      visited[cur] = 1'b1;
    end
    if (weight_mat[cur][0] == 0) begin
      r = '{path_vertex: 0, tour_cost: 0, no_path: 1'b1, last_result: 1'b1};
      queue_result(r);
      return;
    end
    cost += weight_mat[cur][0];
    path[n] = 0;
    for (int k = 0; k <= n; k++) begin
      r.path_vertex = path[k];
      r.tour_cost   = cost[20:0];
      r.no_path     = 1'b0;
      r.last_result = (k == n);
      queue_result(r);
    end
  endtask

  always @(posedge clk) begin
    tsp_out_t e;
    if (!rst_n) begin
      vertex_cnt  <= 5'd16;
      error_count <= 0;
      tour_q.delete();
    end else begin
      if (cfg_we) vertex_cnt <= cfg_wdata;
      if (in_valid && in_ready) begin
        weight_mat[in_data.row_index][in_data.col_index] = in_data.edge_weight;
        if (in_data.last_entry) solve_tour();
      end
      if (out_valid && out_ready) begin
        if (tour_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          error_count <= error_count + 1;
        end else begin
          e = tour_q.pop_front();
          if (e.path_vertex !== out_data.path_vertex || e.tour_cost !== out_data.tour_cost ||
              e.no_path !== out_data.no_path || e.last_result !== out_data.last_result) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, out_data);
            error_count <= error_count + 1;
          end
        end
      end
    end
  end
endmodule

>>> sim/tsp_tour_mst_lookahead_core_tb.sv
`timescale 1ns / 1ps
// Testbench top: drives matrix items and configuration, stalls the output, reports the verdict.
module tsp_tour_mst_lookahead_core_tb;
  import tsp_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [4:0] cfg_wdata = '0;
  int pending_count, error_count;
  int burst_left = 0;
  int stall_mode = 0;

  tsp_if #(.payload_t(tsp_in_t))  in_ch ();
  tsp_if #(.payload_t(tsp_out_t)) out_ch ();

  tsp_tour_mst_lookahead_core u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  tsp_tour_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .pending_count(pending_count), .error_count(error_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    out_ch.ready = 1'b0;
  end

  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_ch.ready = 1'b1;
      1: out_ch.ready = $urandom_range(0, 1);
      default: out_ch.ready = ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic send_entry(int r, int c, logic [15:0] w, bit last);
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.data  = '{row_index: r[3:0], col_index: c[3:0], edge_weight: w, last_entry: last};
    in_ch.valid = 1'b1;
    while (!in_ch.ready) @(negedge clk);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic set_vertex_count(logic [4:0] val);
    while (pending_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [15:0] rand_weight(int zero_pct);
    if ($urandom_range(0, 99) < zero_pct) return 16'd0;
    if ($urandom_range(0, 9) == 0) return 16'hFFFF;
    if ($urandom_range(0, 3) == 0) return 16'($urandom_range(1, 15));
    return 16'($urandom_range(1, 65535));
  endfunction

  initial begin
    int n, cnt;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    set_vertex_count(5'd8);
    for (int r = 0; r < 8; r++)
      for (int c = 0; c < 8; c++)
        send_entry(r, c, rand_weight(10), r == 7 && c == 7);

    set_vertex_count(5'd1);
    send_entry(0, 0, 16'd0, 1'b1);
    send_entry(0, 0, 16'hFFFF, 1'b1);
    set_vertex_count(5'd0);
    send_entry(0, 0, 16'd1, 1'b1);
    set_vertex_count(5'd2);
    send_entry(0, 1, 16'hFFFF, 1'b0);
    send_entry(1, 0, 16'hFFFF, 1'b1);
    send_entry(1, 0, 16'd0, 1'b1);
    set_vertex_count(5'd3);
    send_entry(0, 1, 16'd5, 1'b0);
    send_entry(0, 2, 16'd5, 1'b0);
    send_entry(1, 2, 16'd1, 1'b0);
    send_entry(2, 1, 16'd1, 1'b0);
    send_entry(1, 0, 16'd3, 1'b0);
    send_entry(2, 0, 16'd3, 1'b1);
    send_entry(1, 2, 16'd0, 1'b0);
    send_entry(2, 1, 16'd0, 1'b1);

    cnt = 0;
    while (cnt < 32) begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : $urandom_range(2, 5);
      set_vertex_count(n[4:0]);
      for (int k = $urandom_range(1, 10); k > 0; k--) begin
        send_entry($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                   rand_weight($urandom_range(0, 1) ? 5 : 40), k == 1);
        cnt++;
      end
    end

    while (pending_count != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("status: fail");
    $finish;
  end
endmodule

>>> files.f
hw/rtl/tsp_pkg.sv
hw/rtl/tsp_if.sv
hw/rtl/tsp_tour_mst_lookahead_core.sv
sim/tsp_tour_checker.sv
sim/tsp_tour_mst_lookahead_core_tb.sv
